>>> hdl/rvm_pkg.sv
// Shared constants, codes and controller/datapath interface types for the voice mixer.
`timescale 1ns / 1ps
package rvm_pkg;

    // Clip memory depth in frames; a power of two.
    localparam int CLIP_DEPTH = 65536;
    localparam int AW         = $clog2(CLIP_DEPTH);
    // Width that holds an effective clip length of 1 to CLIP_DEPTH.
    localparam int FW         = $clog2(CLIP_DEPTH + 1);
    // Remainder unit operand width: the integer part of a stepped position is 17 bits.
    localparam int MW         = (FW > 17) ? FW : 17;

    localparam int CFG_IW = 3;
    localparam int CFG_DW = 20;

    localparam logic [CFG_IW-1:0] CFG_CLIP_FRAMES = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_STEREO_CLIP = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_LOOPING     = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_STEP_RATE   = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_GAIN_LEFT   = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_GAIN_RIGHT  = 3'd5;

    localparam logic [16:0] RST_CLIP_FRAMES = 17'd65536;
    localparam logic [19:0] RST_STEP_RATE   = 20'd65536;
    localparam logic [15:0] RST_GAIN        = 16'd32768;

    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_RENDER = 2'd1;
    localparam logic [1:0] MODE_START  = 2'd2;

    typedef struct packed {
        logic capture;
        logic write_mem;
        logic start_play;
        logic mod_start;
        logic mod_src_np;
        logic read_i0;
        logic read_i1;
        logic mul0;
        logic mul1;
        logic mul2;
        logic round;
        logic commit;
        logic load_out;
    } rvm_cmd_t;

    typedef struct packed {
        logic playing;
        logic mod_busy;
    } rvm_status_t;

endpackage

>>> hdl/rvm_mod.sv
// Remainder unit: x mod d, one subtract for small quotients, else one bit per cycle.
`timescale 1ns / 1ps
module rvm_mod (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [rvm_pkg::MW-1:0] x,
    input  logic [rvm_pkg::FW-1:0] d,
    output logic                 busy,
    output logic [rvm_pkg::MW-1:0] rem
);
    import rvm_pkg::*;

    localparam int CW = $clog2(MW);

    logic [MW-1:0] acc_reg, acc_next;
    logic [MW-1:0] x_reg, x_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;

    logic [MW-1:0] d_ext;
    logic [MW:0]   shifted;
    logic [MW+1:0] twice_d;

    assign d_ext   = MW'(d);
    assign twice_d = {1'b0, d_ext, 1'b0};
    assign shifted = {acc_reg, x_reg[MW-1]};

    always_comb
    begin
        acc_next  = acc_reg;
        x_next    = x_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            if (x < d_ext)
            begin
                acc_next = x;
            end
            else if ({2'b00, x} < twice_d)
            begin
                acc_next = x - d_ext;
            end
            else
            begin
                // long division, remainder only
                acc_next  = '0;
                x_next    = x;
                cnt_next  = CW'(MW - 1);
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, d_ext})
            begin
                acc_next = MW'(shifted - {1'b0, d_ext});
            end
            else
            begin
                acc_next = MW'(shifted);
            end
            x_next   = {x_reg[MW-2:0], 1'b0};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        x_reg   <= x_next;
    end

    assign busy = busy_reg;
    assign rem  = acc_reg;

endmodule

>>> hdl/rvm_datapath.sv
// Datapath: configuration, clip memory, voice state, interpolation, gain and mix.
`timescale 1ns / 1ps
module rvm_datapath (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [rvm_pkg::CFG_IW-1:0] cfg_index,
    input  logic [rvm_pkg::CFG_DW-1:0] cfg_data,
    input  logic [1:0]                mode,
    input  logic [15:0]               clip_address,
    input  logic signed [15:0]        sample_left,
    input  logic signed [15:0]        sample_right,
    input  logic signed [18:0]        mix_in_left,
    input  logic signed [18:0]        mix_in_right,
    input  logic                      end_of_buffer,
    input  logic                      final_voice,
    input  rvm_pkg::rvm_cmd_t         cmd,
    output rvm_pkg::rvm_status_t      status,
    output logic signed [18:0]        mix_out_left,
    output logic signed [18:0]        mix_out_right,
    output logic                      voice_active
);
    import rvm_pkg::*;

    function automatic logic signed [16:0] mono(input logic [31:0] w, input logic stereo);
        logic signed [16:0] l;
        logic signed [16:0] r;
        begin
            l = $signed({w[15], w[15:0]});
            r = $signed({w[31], w[31:16]});
            mono = stereo ? (l + r) : (l <<< 1);
        end
    endfunction

    function automatic logic signed [18:0] mix_sat(input logic signed [18:0] m,
                                                   input logic signed [19:0] c,
                                                   input logic fin);
        logic signed [20:0] s;
        begin
            s = m + c;
            if (s > 21'sd262143)
            begin
                s = 21'sd262143;
            end
            else if (s < -21'sd262144)
            begin
                s = -21'sd262144;
            end
            if (fin)
            begin
                if (s > 21'sd32767)
                begin
                    s = 21'sd32767;
                end
                else if (s < -21'sd32768)
                begin
                    s = -21'sd32768;
                end
            end
            mix_sat = s[18:0];
        end
    endfunction

    // configuration
    logic [16:0] clip_frames_reg;
    logic        stereo_reg;
    logic        looping_reg;
    logic [19:0] step_reg;
    logic [15:0] gain_l_reg;
    logic [15:0] gain_r_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_frames_reg <= RST_CLIP_FRAMES;
            stereo_reg      <= 1'b0;
            looping_reg     <= 1'b0;
            step_reg        <= RST_STEP_RATE;
            gain_l_reg      <= RST_GAIN;
            gain_r_reg      <= RST_GAIN;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CLIP_FRAMES: clip_frames_reg <= cfg_data[16:0];
                CFG_STEREO_CLIP: stereo_reg      <= cfg_data[0];
                CFG_LOOPING:     looping_reg     <= cfg_data[0];
                CFG_STEP_RATE:   step_reg        <= cfg_data;
                CFG_GAIN_LEFT:   gain_l_reg      <= cfg_data[15:0];
                CFG_GAIN_RIGHT:  gain_r_reg      <= cfg_data[15:0];
                default:         ;
            endcase
        end
    end

    // effective clip length: zero acts as one, beyond the memory acts as the depth
    logic [FW-1:0] f_eff;

    always_comb
    begin
        if (clip_frames_reg == 17'd0)
        begin
            f_eff = FW'(1);
        end
        else if (32'(clip_frames_reg) > 32'(CLIP_DEPTH))
        begin
            f_eff = FW'(CLIP_DEPTH);
        end
        else
        begin
            f_eff = FW'(clip_frames_reg);
        end
    end

    // captured item
    logic [1:0]         mode_reg;
    logic signed [18:0] mix_l_reg;
    logic signed [18:0] mix_r_reg;
    logic               eob_reg;
    logic               final_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg  <= mode;
            mix_l_reg <= mix_in_left;
            mix_r_reg <= mix_in_right;
            eob_reg   <= end_of_buffer;
            final_reg <= final_voice;
        end
    end

    // voice state
    logic [31:0] pos_reg, pos_next;
    logic        playing_reg, playing_next;
    logic        passed_reg, passed_next;

    // remainder unit
    logic [32:0]   np;
    logic [16:0]   np_int;
    logic [MW-1:0] mod_x;
    logic [MW-1:0] mod_rem;
    logic          mod_busy;
    logic [15:0]   frac_reg;
    logic          wrap_reg;

    assign np     = {1'b0, pos_reg} + 33'(step_reg);
    assign np_int = np[32:16];
    assign mod_x  = cmd.mod_src_np ? MW'(np_int) : MW'(pos_reg[31:16]);

    rvm_mod u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mod_start),
        .x     (mod_x),
        .d     (f_eff),
        .busy  (mod_busy),
        .rem   (mod_rem)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.mod_start && cmd.mod_src_np)
        begin
            frac_reg <= np[15:0];
            wrap_reg <= (MW'(np_int) >= MW'(f_eff));
        end
    end

    always_comb
    begin
        pos_next     = pos_reg;
        playing_next = playing_reg;
        passed_next  = passed_reg;
        if (cmd.start_play)
        begin
            pos_next     = '0;
            passed_next  = 1'b0;
            playing_next = 1'b1;
        end
        else if (cmd.commit)
        begin
            pos_next    = {mod_rem[15:0], frac_reg};
            passed_next = passed_reg | wrap_reg;
            if (eob_reg)
            begin
                // stop a one-shot voice that ran off the clip end
                if (passed_next && !looping_reg)
                begin
                    playing_next = 1'b0;
                    pos_next     = '0;
                end
                passed_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            playing_reg <= 1'b0;
            passed_reg  <= 1'b0;
        end
        else
        begin
            pos_reg     <= pos_next;
            playing_reg <= playing_next;
            passed_reg  <= passed_next;
        end
    end

    // clip memory, left sample in the low half
    logic [31:0]   clip_mem [CLIP_DEPTH];
    logic [31:0]   rd_data_reg;
    logic [AW-1:0] i0_reg;
    logic [AW-1:0] i1;
    logic [AW-1:0] rd_addr;

    assign i1      = ((FW'(i0_reg) + FW'(1)) == f_eff) ? '0 : (i0_reg + AW'(1));
    assign rd_addr = cmd.read_i1 ? i1 : mod_rem[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.write_mem)
        begin
            clip_mem[AW'(clip_address)] <= {sample_right, sample_left};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.read_i0 || cmd.read_i1)
        begin
            rd_data_reg <= clip_mem[rd_addr];
        end
        if (cmd.read_i0)
        begin
            i0_reg <= mod_rem[AW-1:0];
        end
    end

    // interpolation and gain
    logic signed [16:0] s0_reg;
    logic signed [16:0] s1;
    logic signed [17:0] diff;
    logic signed [16:0] t_s;
    logic signed [34:0] s0sh_reg;
    logic signed [34:0] prod_reg;
    logic signed [34:0] v_reg;
    logic signed [51:0] pl_reg;
    logic signed [51:0] pr_reg;
    logic signed [51:0] pl_rnd;
    logic signed [51:0] pr_rnd;
    logic signed [19:0] cl_reg;
    logic signed [19:0] cr_reg;

    assign s1     = mono(rd_data_reg, stereo_reg);
    assign diff   = 18'(s1) - 18'(s0_reg);
    assign t_s    = $signed({1'b0, pos_reg[15:0]});
    assign pl_rnd = pl_reg + (52'sd1 <<< 31);
    assign pr_rnd = pr_reg + (52'sd1 <<< 31);

    always_ff @(posedge clk)
    begin
        if (cmd.read_i1)
        begin
            s0_reg <= mono(rd_data_reg, stereo_reg);
        end
        if (cmd.mul0)
        begin
            prod_reg <= t_s * diff;
            s0sh_reg <= $signed({{2{s0_reg[16]}}, s0_reg, 16'b0});
        end
        if (cmd.mul1)
        begin
            v_reg <= s0sh_reg + prod_reg;
        end
        if (cmd.mul2)
        begin
            pl_reg <= v_reg * $signed({1'b0, gain_l_reg});
            pr_reg <= v_reg * $signed({1'b0, gain_r_reg});
        end
        if (cmd.capture)
        begin
            // a stopped voice adds nothing
            cl_reg <= '0;
            cr_reg <= '0;
        end
        else if (cmd.round)
        begin
            cl_reg <= pl_rnd[51:32];
            cr_reg <= pr_rnd[51:32];
        end
    end

    // result beat
    logic signed [18:0] out_l_reg;
    logic signed [18:0] out_r_reg;
    logic               active_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            if (mode_reg == MODE_RENDER)
            begin
                out_l_reg <= mix_sat(mix_l_reg, cl_reg, final_reg);
                out_r_reg <= mix_sat(mix_r_reg, cr_reg, final_reg);
            end
            else
            begin
                out_l_reg <= '0;
                out_r_reg <= '0;
            end
            active_reg <= playing_reg;
        end
    end

    assign mix_out_left    = out_l_reg;
    assign mix_out_right   = out_r_reg;
    assign voice_active    = active_reg;
    assign status.playing  = playing_reg;
    assign status.mod_busy = mod_busy;

endmodule

>>> hdl/rvm_ctrl.sv
// Controller: sequences load, start and render beats and owns both handshakes.
`timescale 1ns / 1ps
module rvm_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           mode,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  rvm_pkg::rvm_status_t status,
    output rvm_pkg::rvm_cmd_t    cmd
);
    import rvm_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD0   = 3'd1;
    localparam logic [2:0] S_RD1   = 3'd2;
    localparam logic [2:0] S_MUL0  = 3'd3;
    localparam logic [2:0] S_MUL1  = 3'd4;
    localparam logic [2:0] S_MUL2  = 3'd5;
    localparam logic [2:0] S_WAITP = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign in_ready = (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DONE;
                    case (mode)
                        MODE_LOAD:   cmd.write_mem  = 1'b1;
                        MODE_START:  cmd.start_play = 1'b1;
                        MODE_RENDER:
                        begin
                            if (status.playing)
                            begin
                                // fold the position into the clip for the first frame index
                                cmd.mod_start = 1'b1;
                                state_next    = S_RD0;
                            end
                        end
                        default:     ;
                    endcase
                end
            end
            S_RD0:
            begin
                if (!status.mod_busy)
                begin
                    cmd.read_i0 = 1'b1;
                    state_next  = S_RD1;
                end
            end
            S_RD1:
            begin
                cmd.read_i1 = 1'b1;
                state_next  = S_MUL0;
            end
            S_MUL0:
            begin
                cmd.mul0       = 1'b1;
                cmd.mod_start  = 1'b1;
                cmd.mod_src_np = 1'b1;
                state_next     = S_MUL1;
            end
            S_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = S_WAITP;
            end
            S_WAITP:
            begin
                cmd.round = 1'b1;
                if (!status.mod_busy)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // hold until the output register frees up
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

>>> hdl/resampling_voice_mixer.sv
// Top level of one linear-interpolating wavetable voice with chained mix output.
// Load, start and stopped-voice render beats go from idle straight to the done state and the result register.
// Render of a playing voice steps through RD0, RD1, MUL0, MUL1, MUL2, WAITP and DONE; RD0 and WAITP
// wait on the remainder unit when the frame index fold or the wrapped position fold reaches twice
// the clip length; the two frames are read in turn through the single memory read port.
// Reset: registers to defaults, voice stopped at position zero; clip memory is not cleared.
`timescale 1ns / 1ps
module resampling_voice_mixer (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [rvm_pkg::CFG_IW-1:0] cfg_index,
    input  logic [rvm_pkg::CFG_DW-1:0] cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [1:0]                mode,
    input  logic [15:0]               clip_address,
    input  logic signed [15:0]        sample_left,
    input  logic signed [15:0]        sample_right,
    input  logic signed [18:0]        mix_in_left,
    input  logic signed [18:0]        mix_in_right,
    input  logic                      end_of_buffer,
    input  logic                      final_voice,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [18:0]        mix_out_left,
    output logic signed [18:0]        mix_out_right,
    output logic                      voice_active
);
    import rvm_pkg::*;

    rvm_cmd_t    cmd;
    rvm_status_t status;

    rvm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    rvm_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mode          (mode),
        .clip_address  (clip_address),
        .sample_left   (sample_left),
        .sample_right  (sample_right),
        .mix_in_left   (mix_in_left),
        .mix_in_right  (mix_in_right),
        .end_of_buffer (end_of_buffer),
        .final_voice   (final_voice),
        .cmd           (cmd),
        .status        (status),
        .mix_out_left  (mix_out_left),
        .mix_out_right (mix_out_right),
        .voice_active  (voice_active)
    );

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid || out_ready))
        else $error("result loaded over an untaken beat");

    a_idle_mod: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !status.mod_busy)
        else $error("remainder unit busy while idle");

    a_commit_mod: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !status.mod_busy)
        else $error("position committed before wrap finished");

    a_start_plays: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && mode == MODE_START) |=> status.playing)
        else $error("start beat did not set playing");

endmodule

>>> tb/rvm_mix_checker.sv
// Checker for the voice mixer: tracks register writes, predicts each result beat and compares.
`timescale 1ns / 1ps
module rvm_mix_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [rvm_pkg::CFG_IW-1:0] cfg_index,
    input  logic [rvm_pkg::CFG_DW-1:0] cfg_data,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic [1:0]                 mode,
    input  logic [15:0]                clip_address,
    input  logic signed [15:0]         sample_left,
    input  logic signed [15:0]         sample_right,
    input  logic signed [18:0]         mix_in_left,
    input  logic signed [18:0]         mix_in_right,
    input  logic                       end_of_buffer,
    input  logic                       final_voice,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic signed [18:0]         mix_out_left,
    input  logic signed [18:0]         mix_out_right,
    input  logic                       voice_active,
    output int                         mismatch_count,
    output int                         results_pending
);
    import rvm_pkg::*;

    localparam longint MIX_HI = 262143;
    localparam longint MIX_LO = -262144;
    localparam longint OUT_HI = 32767;
    localparam longint OUT_LO = -32768;

    typedef struct packed {
        logic signed [18:0] left;
        logic signed [18:0] right;
        logic               active;
    } mix_beat_t;

    // Shadow of the voice: frame store, position and flags
    logic [31:0] clip_mem [0:CLIP_DEPTH-1];
    logic [31:0] voice_pos;
    logic        playing;
    logic        past_end;

    logic [16:0] cfg_frames;
    logic        cfg_stereo;
    logic        cfg_loop;
    logic [19:0] cfg_step;
    logic [15:0] cfg_gain_l;
    logic [15:0] cfg_gain_r;

    mix_beat_t mix_expect_q[$];
    mix_beat_t want;

    function automatic longint saturate(longint x, longint lo, longint hi);
        if (x < lo)
            return lo;
        if (x > hi)
            return hi;
        return x;
    endfunction

    // floor((x + 2^31) / 2^32): round half up out of the Q.32 product
    function automatic longint round_q32(longint x);
        return (x + 64'sd2147483648) >>> 32;
    endfunction

    // Mono sample of one frame as a 17-bit signed integer: both channels summed, or twice the left one
    function automatic longint frame_mono(longint idx);
        logic [31:0] w;
        w = clip_mem[idx];
        if (cfg_stereo)
            return longint'($signed(w[15:0])) + longint'($signed(w[31:16]));
        return 2 * longint'($signed(w[15:0]));
    endfunction

    function automatic mix_beat_t advance_voice();
        mix_beat_t r;
        longint f, i0, i1, frac, s0, s1, v, add_l, add_r, np, lim, ml, mr;
        add_l = 0;
        add_r = 0;
        ml = 0;
        mr = 0;
        case (mode)
            MODE_LOAD:
                clip_mem[clip_address] = {sample_right, sample_left};
            MODE_START:
            begin
                voice_pos = '0;
                past_end = 1'b0;
                playing = 1'b1;
            end
            MODE_RENDER:
            begin
                if (playing)
                begin
                    f = cfg_frames;
                    if (f == 0)
                        f = 1;
                    if (f > CLIP_DEPTH)
                        f = CLIP_DEPTH;
                    i0 = longint'(voice_pos[31:16]) % f;
                    i1 = (i0 + 1) % f;
                    frac = voice_pos[15:0];
                    s0 = frame_mono(i0);
                    s1 = frame_mono(i1);
                    v = s0 * 65536 + frac * (s1 - s0);
                    add_l = round_q32(v * longint'(cfg_gain_l));
                    add_r = round_q32(v * longint'(cfg_gain_r));
                    lim = f << 16;
                    np = voice_pos + cfg_step;
                    if (np >= lim)
                    begin
                        past_end = 1'b1;
                        np = np % lim;
                    end
                    voice_pos = np[31:0];
                    // buffer end: drop a one-shot voice that ran off the clip
                    if (end_of_buffer)
                    begin
                        if (past_end && !cfg_loop)
                        begin
                            playing = 1'b0;
                            voice_pos = '0;
                        end
                        past_end = 1'b0;
                    end
                end
                ml = saturate(longint'(mix_in_left) + add_l, MIX_LO, MIX_HI);
                mr = saturate(longint'(mix_in_right) + add_r, MIX_LO, MIX_HI);
                if (final_voice)
                begin
                    ml = saturate(ml, OUT_LO, OUT_HI);
                    mr = saturate(mr, OUT_LO, OUT_HI);
                end
            end
            default: ;
        endcase
        r.left = ml[18:0];
        r.right = mr[18:0];
        r.active = playing;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            voice_pos = '0;
            playing = 1'b0;
            past_end = 1'b0;
            cfg_frames = RST_CLIP_FRAMES;
            cfg_stereo = 1'b0;
            cfg_loop = 1'b0;
            cfg_step = RST_STEP_RATE;
            cfg_gain_l = RST_GAIN;
            cfg_gain_r = RST_GAIN;
            mix_expect_q.delete();
            mismatch_count = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CLIP_FRAMES: cfg_frames = cfg_data[16:0];
                    CFG_STEREO_CLIP: cfg_stereo = cfg_data[0];
                    CFG_LOOPING:     cfg_loop = cfg_data[0];
                    CFG_STEP_RATE:   cfg_step = cfg_data[19:0];
                    CFG_GAIN_LEFT:   cfg_gain_l = cfg_data[15:0];
                    CFG_GAIN_RIGHT:  cfg_gain_r = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (mix_expect_q.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected: left %0d right %0d active %0b",
                             $time, mix_out_left, mix_out_right, voice_active);
                    mismatch_count++;
                end
                else
                begin
                    want = mix_expect_q.pop_front();
                    if (mix_out_left !== want.left)
                    begin
                        $display("%0t: mix_out_left expected %0d, got %0d",
                                 $time, want.left, mix_out_left);
                        mismatch_count++;
                    end
                    if (mix_out_right !== want.right)
                    begin
                        $display("%0t: mix_out_right expected %0d, got %0d",
                                 $time, want.right, mix_out_right);
                        mismatch_count++;
                    end
                    if (voice_active !== want.active)
                    begin
                        $display("%0t: voice_active expected %0b, got %0b",
                                 $time, want.active, voice_active);
                        mismatch_count++;
                    end
                end
            end
            if (in_valid && in_ready)
                mix_expect_q.push_back(advance_voice());
        end
        results_pending = mix_expect_q.size();
    end

endmodule

>>> tb/tb_resampling_voice_mixer.sv
// Testbench top for the voice mixer: clock, reset, stimulus, flow control and verdict.
`timescale 1ns / 1ps
module tb_resampling_voice_mixer;
    import rvm_pkg::*;

    localparam logic [1:0]         MODE_UNUSED   = 2'd3;
    localparam logic signed [18:0] MIX_TOP       = 19'sd262143;
    localparam logic signed [18:0] MIX_BOTTOM    = -19'sd262144;
    localparam int                 SETTLE_CYCLES = 64;
    localparam int                 CYCLE_LIMIT   = 1000000;
    localparam int                 STALL_CYCLES  = 400;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [CFG_IW-1:0]   cfg_index;
    logic [CFG_DW-1:0]   cfg_data;
    logic                in_valid;
    logic                in_ready;
    logic [1:0]          mode;
    logic [15:0]         clip_address;
    logic signed [15:0]  sample_left;
    logic signed [15:0]  sample_right;
    logic signed [18:0]  mix_in_left;
    logic signed [18:0]  mix_in_right;
    logic                end_of_buffer;
    logic                final_voice;
    logic                out_valid;
    logic                out_ready;
    logic signed [18:0]  mix_out_left;
    logic signed [18:0]  mix_out_right;
    logic                voice_active;

    int   mismatch_count;
    int   results_pending;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   cycle_count;
    logic hold_off_req;

    resampling_voice_mixer u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .clip_address  (clip_address),
        .sample_left   (sample_left),
        .sample_right  (sample_right),
        .mix_in_left   (mix_in_left),
        .mix_in_right  (mix_in_right),
        .end_of_buffer (end_of_buffer),
        .final_voice   (final_voice),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .mix_out_left  (mix_out_left),
        .mix_out_right (mix_out_right),
        .voice_active  (voice_active)
    );

    rvm_mix_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .mode            (mode),
        .clip_address    (clip_address),
        .sample_left     (sample_left),
        .sample_right    (sample_right),
        .mix_in_left     (mix_in_left),
        .mix_in_right    (mix_in_right),
        .end_of_buffer   (end_of_buffer),
        .final_voice     (final_voice),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .mix_out_left    (mix_out_left),
        .mix_out_right   (mix_out_right),
        .voice_active    (voice_active),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Result side: random back-pressure, plus one long hold-off on request
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                stall_left = STALL_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offer one beat and hold it until accepted; returns at a falling edge
    task automatic send_beat(input logic [1:0] m, input logic [15:0] addr,
                             input logic [15:0] sl, input logic [15:0] sr,
                             input logic [18:0] mil, input logic [18:0] mir,
                             input logic eob, input logic fin);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid      <= 1'b1;
        mode          <= m;
        clip_address  <= addr;
        sample_left   <= sl;
        sample_right  <= sr;
        mix_in_left   <= mil;
        mix_in_right  <= mir;
        end_of_buffer <= eob;
        final_voice   <= fin;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Hold the input until every result is back, then let the pipe settle
    task automatic drain_voice();
        in_valid <= 1'b0;
        while (results_pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Mix input: full range, near the saturation bounds, or moderate
    function automatic logic [18:0] rand_mix();
        int tmp;
        case ($urandom_range(3))
            0: tmp = $urandom;
            1: tmp = $urandom_range(1) ? 262143 - $urandom_range(3000)
                                       : -262144 + $urandom_range(3000);
            default: tmp = int'($urandom_range(80000)) - 40000;
        endcase
        return tmp[18:0];
    endfunction

    task automatic run_phase(input logic [16:0] frames, input logic stereo,
                             input logic loop_on, input logic [19:0] step,
                             input logic [15:0] gl, input logic [15:0] gr,
                             input int beats, input bit long_stall);
        int     eff;
        int     loaded;
        int     k;
        int     pick;
        longint pos_shadow;
        drain_voice();
        cfg_write(CFG_CLIP_FRAMES, frames);
        cfg_write(CFG_STEREO_CLIP, stereo);
        cfg_write(CFG_LOOPING, loop_on);
        cfg_write(CFG_STEP_RATE, step);
        cfg_write(CFG_GAIN_LEFT, gl);
        cfg_write(CFG_GAIN_RIGHT, gr);
        eff = (frames == 0) ? 1 : ((frames > CLIP_DEPTH) ? CLIP_DEPTH : frames);
        // long clips are only loaded at the head; renders stay inside it
        loaded = (eff <= 64) ? eff : 32;
        for (k = 0; k < loaded; k++)
            send_beat(MODE_LOAD, k[15:0], $urandom, $urandom, rand_mix(), rand_mix(),
                      $urandom_range(1), $urandom_range(1));
        send_beat(MODE_START, $urandom, $urandom, $urandom, rand_mix(), rand_mix(), 0, 0);
        pos_shadow = 0;
        if (long_stall)
            hold_off_req = 1'b1;
        for (k = 0; k < beats; k++)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                if (eff > loaded && (pos_shadow >>> 16) + 1 >= loaded)
                begin
                    send_beat(MODE_START, $urandom, $urandom, $urandom,
                              rand_mix(), rand_mix(), 0, 0);
                    pos_shadow = 0;
                end
                else
                begin
                    send_beat(MODE_RENDER, $urandom, $urandom, $urandom, rand_mix(), rand_mix(),
                              ($urandom_range(7) == 0), $urandom_range(1));
                    pos_shadow += step;
                end
            end
            else if (pick < 82)
                send_beat(MODE_LOAD, $urandom_range(loaded - 1), $urandom, $urandom,
                          rand_mix(), rand_mix(), $urandom_range(1), $urandom_range(1));
            else if (pick < 88)
                send_beat(MODE_LOAD, $urandom, $urandom, $urandom, rand_mix(), rand_mix(),
                          $urandom_range(1), $urandom_range(1));
            else if (pick < 96)
            begin
                send_beat(MODE_START, $urandom, $urandom, $urandom, rand_mix(), rand_mix(),
                          $urandom_range(1), $urandom_range(1));
                pos_shadow = 0;
            end
            else
                send_beat(MODE_UNUSED, $urandom, $urandom, $urandom, rand_mix(), rand_mix(),
                          $urandom_range(1), $urandom_range(1));
        end
    endtask

    task automatic random_phase(input int beats);
        logic [19:0] step;
        step = $urandom_range(1) ? $urandom_range(20'hFFFFF) : $urandom_range(200000, 20000);
        run_phase($urandom_range(48, 16), $urandom_range(1), $urandom_range(1), step,
                  $urandom_range(65535), $urandom_range(65535), beats, 1'b0);
    endtask

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        mode          = MODE_LOAD;
        clip_address  = '0;
        sample_left   = '0;
        sample_right  = '0;
        mix_in_left   = '0;
        mix_in_right  = '0;
        end_of_buffer = 1'b0;
        final_voice   = 1'b0;
        hold_off_req  = 1'b0;
        cycle_count   = 0;
        send_idle_pct = 31;
        recv_idle_pct = 55;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Stopped voice: the mix passes through, saturated and clamped; unused and load beats give zero
        send_beat(MODE_RENDER, 16'h0000, 16'h0000, 16'h0000, MIX_TOP, MIX_BOTTOM, 0, 0);
        send_beat(MODE_RENDER, 16'h1234, 16'h0000, 16'h0000, MIX_TOP, MIX_BOTTOM, 1, 1);
        send_beat(MODE_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, MIX_TOP, MIX_TOP, 1, 1);
        send_beat(MODE_LOAD, 16'hFFFF, 16'h7FFF, 16'h8000, 0, 0, 0, 0);
        // Frames with full-scale and sign-edge samples
        send_beat(MODE_LOAD, 16'd0, 16'h7FFF, 16'h7FFF, 0, 0, 0, 0);
        send_beat(MODE_LOAD, 16'd1, 16'h8000, 16'h8000, 0, 0, 0, 0);
        send_beat(MODE_LOAD, 16'd2, 16'h7FFF, 16'h8000, 0, 0, 0, 0);
        send_beat(MODE_LOAD, 16'd3, 16'h8000, 16'h7FFF, 0, 0, 0, 0);
        send_beat(MODE_LOAD, 16'd4, 16'h0000, 16'hFFFF, 0, 0, 0, 0);
        send_beat(MODE_LOAD, 16'd5, 16'hFFFF, 16'h0001, 0, 0, 0, 0);
        send_beat(MODE_LOAD, 16'd6, 16'h4000, 16'hC000, 0, 0, 0, 0);
        send_beat(MODE_LOAD, 16'd7, 16'h0001, 16'h0000, 0, 0, 0, 0);
        send_beat(MODE_START, 16'd0, 16'h0000, 16'h0000, 0, 0, 0, 0);
        send_beat(MODE_RENDER, 16'd0, 16'h0000, 16'h0000, 0, 0, 0, 0);
        send_beat(MODE_RENDER, 16'd0, 16'h0000, 16'h0000, MIX_TOP, MIX_TOP, 0, 0);
        send_beat(MODE_RENDER, 16'd0, 16'h0000, 16'h0000, MIX_BOTTOM, MIX_BOTTOM, 0, 0);
        send_beat(MODE_RENDER, 16'd0, 16'h0000, 16'h0000, 19'sd40000, -19'sd40000, 0, 1);
        send_beat(MODE_RENDER, 16'd0, 16'h0000, 16'h0000, rand_mix(), rand_mix(), 1, 0);
        send_beat(MODE_RENDER, 16'd0, 16'h0000, 16'h0000, -19'sd1, 19'sd1, 0, 1);
        send_beat(MODE_START, 16'd0, 16'h0000, 16'h0000, 0, 0, 0, 0);

        // Register extremes: shortest clip, zero and oversized lengths, zero and top rate
        run_phase(17'd16, 1'b0, 1'b0, 20'd65536, 16'hFFFF, 16'h0000, 110, 1'b0);
        run_phase(17'd0, 1'b1, 1'b1, 20'hFFFFF, 16'h8000, 16'hFFFF, 80, 1'b0);
        run_phase(17'd65536, 1'b0, 1'b0, 20'd40000, $urandom, $urandom, 80, 1'b0);
        run_phase(17'h1FFFF, 1'b1, 1'b1, 20'd3000, $urandom, $urandom, 80, 1'b0);
        run_phase(17'd17, 1'b1, 1'b0, 20'd0, 16'h0000, 16'h0000, 60, 1'b0);

        send_idle_pct = 55;
        recv_idle_pct = 31;
        run_phase(17'd64, 1'b0, 1'b1, 20'd1, 16'hFFFF, 16'hFFFF, 120, 1'b1);
        repeat (4) random_phase(90);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (5) random_phase(90);

        drain_voice();
        if (mismatch_count == 0 && results_pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> files.f
hdl/rvm_pkg.sv
hdl/rvm_mod.sv
hdl/rvm_datapath.sv
hdl/rvm_ctrl.sv
hdl/resampling_voice_mixer.sv
tb/rvm_mix_checker.sv
tb/tb_resampling_voice_mixer.sv
